// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the RTL. Bodies vanish in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/abkf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package abkf_pkg;

    // Register indexes
    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

    // Register reset values (Q8.24)
    localparam logic [31:0] APN_RST = 32'd16777;
    localparam logic [31:0] BPN_RST = 32'd50332;
    localparam logic [31:0] MN_RST  = 32'd503316;

    localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_T_SUB1,
        ST_T_SUB2,
        ST_T_ADD,
        ST_S_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_ANG_PRED,
        OP_DTP11,
        OP_P00_PRED,
        OP_P11_PRED,
        OP_ANG_CORR,
        OP_BIAS_CORR,
        OP_P00_CORR,
        OP_P01_CORR,
        OP_P10_CORR,
        OP_P11_CORR
    } t_op;

    // Right shift applied to a product
    typedef enum logic [1:0] {
        SH_16,
        SH_24,
        SH_32
    } t_shift;

    // Status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    // Signed value from a 128 bit magnitude, saturated to 64 bits
    function automatic logic signed [63:0] sat_mag(input logic [127:0] m, input logic neg);
        logic signed [63:0] r;
        if (|m[127:63]) begin
            r = neg ? MIN64 : MAX64;
        end else begin
            r = neg ? (64'sd0 - $signed(m[63:0])) : $signed(m[63:0]);
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            r = s[64] ? MIN64 : MAX64;
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] ssub64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            r = s[64] ? MIN64 : MAX64;
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/abkf_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// 64x64 signed multiply through one 32x32 multiplier over four partial
// products, then truncating shift and 64 bit saturation.
module abkf_mul (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire  logic signed [63:0] i_a,
    input  wire  logic signed [63:0] i_b,
    input  wire  abkf_pkg::t_shift   i_shift,
    output logic signed [63:0]       o_res,
    output abkf_pkg::t_unit_stat     o_stat
);
    import abkf_pkg::*;

    logic [63:0]  r_am;
    logic [63:0]  r_bm;
    logic         r_neg;
    t_shift       r_sh;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [63:0]  r_pp;
    logic [127:0] r_acc;
    logic signed [63:0] r_res;

    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [127:0] pp_shifted;
    logic [127:0] acc_shr;

    // Partial product operand select: lo*lo, lo*hi, hi*lo, hi*hi
    always_comb begin
        case (r_cnt)
            3'd0:    begin op_a = r_am[31:0];  op_b = r_bm[31:0];  end
            3'd1:    begin op_a = r_am[31:0];  op_b = r_bm[63:32]; end
            3'd2:    begin op_a = r_am[63:32]; op_b = r_bm[31:0];  end
            default: begin op_a = r_am[63:32]; op_b = r_bm[63:32]; end
        endcase
    end

    // Weight of the product registered in the previous step
    always_comb begin
        case (r_cnt)
            3'd1:    pp_shifted = {64'd0, r_pp};
            3'd2:    pp_shifted = {32'd0, r_pp, 32'd0};
            3'd3:    pp_shifted = {32'd0, r_pp, 32'd0};
            default: pp_shifted = {r_pp, 64'd0};
        endcase
    end

    always_comb begin
        case (r_sh)
            SH_16:   acc_shr = r_acc >> 16;
            SH_24:   acc_shr = r_acc >> 24;
            default: acc_shr = r_acc >> 32;
        endcase
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_am  <= mag64(i_a);
            r_bm  <= mag64(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_sh  <= i_shift;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt <= 3'd3) begin
                r_pp <= op_a * op_b;
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + pp_shifted;
            end
            if (r_cnt == 3'd5) begin
                r_res <= sat_mag(acc_shr, r_neg);
            end
        end
    end

    assign o_res       = r_res;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ----- rtl/abkf_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit a cycle: (n * 2^32) / d, magnitude
// truncated, saturated to 64 bits, in 128 steps.
module abkf_div (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire  logic signed [63:0] i_num,
    input  wire  logic signed [63:0] i_den,
    output logic signed [63:0]       o_quo,
    output abkf_pkg::t_unit_stat     o_stat
);
    import abkf_pkg::*;

    logic [127:0] r_num;
    logic [63:0]  r_rem;
    logic [63:0]  r_dm;
    logic [63:0]  r_q;
    logic         r_ovf;
    logic         r_neg;
    logic [6:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic signed [63:0] r_quo;

    logic [64:0]  rem_sh;
    logic         q_bit;
    logic [63:0]  n_rem;
    logic [63:0]  n_q;
    logic         n_ovf;
    logic [64:0]  rem_diff;

    // One trial subtraction
    always_comb begin
        rem_sh   = {r_rem, r_num[127]};
        rem_diff = rem_sh - {1'b0, r_dm};
        q_bit    = (rem_sh >= {1'b0, r_dm});
        n_rem    = q_bit ? rem_diff[63:0] : rem_sh[63:0];
        n_q      = {r_q[62:0], q_bit};
        n_ovf    = r_ovf | r_q[63];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd127;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= {32'd0, mag64(i_num), 32'd0};
            r_dm  <= mag64(i_den);
            r_neg <= i_num[63] ^ i_den[63];
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[126:0], 1'b0};
            r_rem <= n_rem;
            r_q   <= n_q;
            r_ovf <= n_ovf;
            if (r_cnt == 7'd0) begin
                r_quo <= sat_mag({63'd0, n_ovf, n_q}, r_neg);
            end
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ----- rtl/angle_bias_kalman_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Two-state Kalman filter for tilt angle and gyro bias.
// Input channel: i_valid / o_stall with measured angle, measured rate
// (signed Q16.16) and elapsed time (unsigned Q1.24). A request is taken at
// a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with filtered angle, estimated bias and
// bias-corrected rate, one result per request.
// Config: i_cfg_we / i_cfg_idx / i_cfg_data write the angle, bias and
// measurement noise (unsigned Q8.24); index 3 is ignored. Write only idle.
// Arithmetic: one shared 64x64 multiplier (four 32x32 steps, ten products)
// and a one-bit-per-cycle divider (two gains) do the math. The division is
// skipped when the innovation covariance is zero.
// o_stall is high for the whole update; one request can be taken while
// the previous result still waits in the output register.
// Reset (synchronous, active low) clears angle, bias and covariance and
// loads the default noise values. A stalled result holds; the next update
// finishes its math and waits for the output register to drain.
`include "assert_macros.svh"

module angle_bias_kalman_filter #(
    parameter int COVARIANCE_WIDTH = 48
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  logic signed [31:0] i_measured_angle,
    input  wire  logic signed [31:0] i_measured_rate,
    input  wire  logic [24:0]  i_elapsed_time,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_filtered_angle,
    output logic signed [31:0] o_estimated_bias,
    output logic signed [31:0] o_corrected_rate,
    input  wire                i_cfg_we,
    input  wire  logic [1:0]   i_cfg_idx,
    input  wire  logic [31:0]  i_cfg_data
);
    import abkf_pkg::*;

    localparam int CW = COVARIANCE_WIDTH;
    localparam logic signed [63:0] COV_MAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] COV_MIN = -COV_MAX - 64'sd1;

    function automatic logic signed [CW-1:0] clamp_cov(input logic signed [63:0] x);
        logic signed [63:0] v;
        v = (x > COV_MAX) ? COV_MAX : ((x < COV_MIN) ? COV_MIN : x);
        return v[CW-1:0];
    endfunction

    function automatic logic signed [63:0] ext_cov(input logic signed [CW-1:0] x);
        return 64'(x);
    endfunction

    // Configuration
    logic [31:0] r_apn;
    logic [31:0] r_bpn;
    logic [31:0] r_mn;

    // Filter state
    logic signed [31:0]   r_angle;
    logic signed [31:0]   r_bias;
    logic signed [CW-1:0] r_p00;
    logic signed [CW-1:0] r_p01;
    logic signed [CW-1:0] r_p10;
    logic signed [CW-1:0] r_p11;

    // Working registers
    t_state             r_state;
    t_state             n_state;
    t_op                r_op;
    logic signed [31:0] r_ma;
    logic [24:0]        r_dt;
    logic signed [31:0] r_rate;
    logic signed [63:0] r_dtp11;
    logic signed [63:0] r_t;
    logic signed [63:0] r_s;
    logic signed [63:0] r_y;
    logic signed [63:0] r_k0;
    logic signed [63:0] r_k1;
    logic signed [63:0] r_p00s;
    logic signed [63:0] r_p01s;
    logic               r_dsel;
    logic               r_ovalid;
    logic signed [31:0] r_oangle;
    logic signed [31:0] r_obias;
    logic signed [31:0] r_orate;

    // Shared units
    logic               mul_start;
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    t_shift             mul_sh;
    logic signed [63:0] mul_res;
    t_unit_stat         mul_stat;
    logic               div_start;
    logic signed [63:0] div_num;
    logic signed [63:0] div_quo;
    t_unit_stat         div_stat;

    logic               accept;
    logic               out_take;
    logic signed [63:0] s_sum;
    logic signed [63:0] dt64;
    logic signed [32:0] rate_diff;

    assign accept   = i_valid && !o_stall;
    assign out_take = r_ovalid && !i_stall;
    assign dt64     = $signed({39'd0, r_dt});
    assign s_sum    = sadd64(ext_cov(r_p00), $signed({24'd0, r_mn, 8'd0}));
    assign rate_diff = {i_measured_rate[31], i_measured_rate} - {r_bias[31], r_bias};

    abkf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_shift (mul_sh),
        .o_res   (mul_res),
        .o_stat  (mul_stat)
    );

    abkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_s),
        .o_quo   (div_quo),
        .o_stat  (div_stat)
    );

    // Multiplier operand select per step
    always_comb begin
        case (r_op)
            OP_ANG_PRED:  begin mul_a = dt64;  mul_b = 64'(r_rate);     mul_sh = SH_24; end
            OP_DTP11:     begin mul_a = dt64;  mul_b = ext_cov(r_p11);  mul_sh = SH_24; end
            OP_P00_PRED:  begin mul_a = dt64;  mul_b = r_t;             mul_sh = SH_24; end
            OP_P11_PRED:  begin
                mul_a = $signed({32'd0, r_bpn}); mul_b = dt64; mul_sh = SH_16;
            end
            OP_ANG_CORR:  begin mul_a = r_k0;  mul_b = r_y;             mul_sh = SH_32; end
            OP_BIAS_CORR: begin mul_a = r_k1;  mul_b = r_y;             mul_sh = SH_32; end
            OP_P00_CORR:  begin mul_a = r_k0;  mul_b = r_p00s;          mul_sh = SH_32; end
            OP_P01_CORR:  begin mul_a = r_k0;  mul_b = r_p01s;          mul_sh = SH_32; end
            OP_P10_CORR:  begin mul_a = r_k1;  mul_b = r_p00s;          mul_sh = SH_32; end
            default:      begin mul_a = r_k1;  mul_b = r_p01s;          mul_sh = SH_32; end
        endcase
    end

    assign div_num = r_dsel ? ext_cov(r_p10) : ext_cov(r_p00);

    // Sequencer next state and strobes
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE:     if (i_valid) n_state = ST_MUL_GO;
            ST_MUL_GO:   begin
                mul_start = 1'b1;
                n_state   = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mul_stat.done) begin
                    case (r_op)
                        OP_DTP11:    n_state = ST_T_SUB1;
                        OP_P11_PRED: n_state = ST_S_SUM;
                        OP_P11_CORR: n_state = ST_OUT;
                        default:     n_state = ST_MUL_GO;
                    endcase
                end
            end
            ST_T_SUB1:   n_state = ST_T_SUB2;
            ST_T_SUB2:   n_state = ST_T_ADD;
            ST_T_ADD:    n_state = ST_MUL_GO;
            ST_S_SUM:    n_state = (s_sum == 64'sd0) ? ST_MUL_GO : ST_DIV_GO;
            ST_DIV_GO:   begin
                div_start = 1'b1;
                n_state   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) n_state = r_dsel ? ST_MUL_GO : ST_DIV_GO;
            end
            ST_OUT:      if (!r_ovalid || !i_stall) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apn <= APN_RST;
            r_bpn <= BPN_RST;
            r_mn  <= MN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ANGLE_NOISE: r_apn <= i_cfg_data;
                REG_BIAS_NOISE:  r_bpn <= i_cfg_data;
                REG_MEAS_NOISE:  r_mn  <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // Filter state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle  <= '0;
            r_bias   <= '0;
            r_p00    <= '0;
            r_p01    <= '0;
            r_p10    <= '0;
            r_p11    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // A finished update refills the output register, a taken result empties it
            if (r_state == ST_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (out_take) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_MUL_WAIT: begin
                    if (mul_stat.done) begin
                        case (r_op)
                            OP_ANG_PRED, OP_ANG_CORR:
                                r_angle <= clamp32(sadd64(64'(r_angle), mul_res));
                            OP_BIAS_CORR:
                                r_bias <= clamp32(sadd64(64'(r_bias), mul_res));
                            OP_P00_PRED:
                                r_p00 <= clamp_cov(sadd64(ext_cov(r_p00), mul_res));
                            OP_P11_PRED:
                                r_p11 <= clamp_cov(sadd64(ext_cov(r_p11), mul_res));
                            OP_P00_CORR:
                                r_p00 <= clamp_cov(ssub64(ext_cov(r_p00), mul_res));
                            OP_P01_CORR:
                                r_p01 <= clamp_cov(ssub64(ext_cov(r_p01), mul_res));
                            OP_P10_CORR:
                                r_p10 <= clamp_cov(ssub64(ext_cov(r_p10), mul_res));
                            OP_P11_CORR:
                                r_p11 <= clamp_cov(ssub64(ext_cov(r_p11), mul_res));
                            default: ;
                        endcase
                    end
                end
                ST_T_ADD: begin
                    r_p01 <= clamp_cov(ssub64(ext_cov(r_p01), r_dtp11));
                    r_p10 <= clamp_cov(ssub64(ext_cov(r_p10), r_dtp11));
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_ma   <= i_measured_angle;
                    r_dt   <= i_elapsed_time;
                    r_rate <= clamp32(64'(rate_diff));
                    r_op   <= OP_ANG_PRED;
                end
            end
            ST_MUL_WAIT: begin
                if (mul_stat.done) begin
                    if (r_op == OP_DTP11) r_dtp11 <= mul_res;
                    if (r_op != OP_P11_CORR) r_op <= t_op'(r_op + 4'd1);
                end
            end
            ST_T_SUB1: r_t <= ssub64(r_dtp11, ext_cov(r_p01));
            ST_T_SUB2: r_t <= ssub64(r_t, ext_cov(r_p10));
            ST_T_ADD:  r_t <= sadd64(r_t, $signed({24'd0, r_apn, 8'd0}));
            ST_S_SUM: begin
                r_s    <= s_sum;
                r_y    <= 64'(r_ma) - 64'(r_angle);
                r_p00s <= ext_cov(r_p00);
                r_p01s <= ext_cov(r_p01);
                r_dsel <= 1'b0;
                r_k0   <= '0;
                r_k1   <= '0;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    if (r_dsel) begin
                        r_k1 <= div_quo;
                    end else begin
                        r_k0 <= div_quo;
                    end
                    r_dsel <= 1'b1;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    r_oangle <= r_angle;
                    r_obias  <= r_bias;
                    r_orate  <= r_rate;
                end
            end
            default: ;
        endcase
    end

    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = r_ovalid;
    assign o_filtered_angle = r_oangle;
    assign o_estimated_bias = r_obias;
    assign o_corrected_rate = r_orate;

    // Shared units are only started when free, the divider never by zero
    `ASSERT_IMPLY(a_mul_free, i_clk, i_rst_n, mul_start, !mul_stat.busy)
    `ASSERT_IMPLY(a_div_free, i_clk, i_rst_n, div_start, !div_stat.busy)
    `ASSERT_IMPLY(a_div_nonzero, i_clk, i_rst_n, div_start, r_s != 64'sd0)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != ST_IDLE)
    `ASSERT_IMPLY(a_out_from_seq, i_clk, i_rst_n, $rose(o_valid), $past(r_state) == ST_OUT)

endmodule

`default_nettype wire

// ----- dv/tb_angle_bias_kalman_filter.sv -----
`timescale 1ns / 1ps

module tb_angle_bias_kalman_filter;
    import abkf_pkg::*;

    localparam int COV_W       = 48;
    localparam int WDOG_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 400;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] bias;
        logic signed [31:0] rate;
    } t_filter_out;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_measured_angle;
    logic signed [31:0] i_measured_rate;
    logic [24:0]        i_elapsed_time;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_filtered_angle;
    logic signed [31:0] o_estimated_bias;
    logic signed [31:0] o_corrected_rate;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;

    // Filter state mirrored in the testbench
    logic [31:0]        q_angle_noise;
    logic [31:0]        q_bias_noise;
    logic [31:0]        r_meas_noise;
    logic signed [63:0] est_angle;
    logic signed [63:0] est_bias;
    logic signed [63:0] cov [4];

    t_filter_out expected_q[$];
    int  err_cnt;
    int  req_cnt;
    int  rsp_cnt;
    int  cfg_cnt;
    int  quiet_cycles;
    bit  idle_on;
    int  hold_cycles;
    int  stall_left;

    angle_bias_kalman_filter #(.COVARIANCE_WIDTH(COV_W)) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_measured_angle (i_measured_angle),
        .i_measured_rate  (i_measured_rate),
        .i_elapsed_time   (i_elapsed_time),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_filtered_angle (o_filtered_angle),
        .o_estimated_bias (o_estimated_bias),
        .o_corrected_rate (o_corrected_rate),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------- fixed-point helpers ----------------
    function automatic logic [63:0] abs64(input logic signed [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    // Signed value from a magnitude, saturated to 64 bits
    function automatic logic signed [63:0] to_signed_sat(input logic [127:0] m, input bit neg);
        if (|m[127:63]) return neg ? S64_MIN : S64_MAX;
        return neg ? $signed(64'd0 - m[63:0]) : $signed(m[63:0]);
    endfunction

    // (a*b) >> sh with magnitude truncation
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b, input int sh);
        logic [127:0] prod;
        prod = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        return to_signed_sat(prod >> sh, a[63] ^ b[63]);
    endfunction

    // (n << 32) / d with magnitude truncation
    function automatic logic signed [63:0] fx_gain(input logic signed [63:0] n,
                                                   input logic signed [63:0] d);
        logic [127:0] num;
        num = {64'd0, abs64(n)} << 32;
        return to_signed_sat(num / {64'd0, abs64(d)}, n[63] ^ d[63]);
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_cov(input logic signed [63:0] x);
        logic signed [63:0] hi_lim;
        hi_lim = (64'sd1 <<< (COV_W - 1)) - 64'sd1;
        if (x > hi_lim) return hi_lim;
        if (x < -hi_lim - 64'sd1) return -hi_lim - 64'sd1;
        return x;
    endfunction

    function automatic logic signed [63:0] sat_q16(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // One predict + correct step; returns the expected outputs
    function automatic t_filter_out kf_update(input logic signed [31:0] meas_ang,
                                              input logic signed [31:0] meas_rate,
                                              input logic [24:0] dt_in);
        logic signed [63:0] dt, rate, dtp11, t, s, k0, k1, y, p00, p01;
        t_filter_out r;
        dt = {39'd0, dt_in};
        rate = sat_q16(64'(meas_rate) - est_bias);
        est_angle = sat_q16(add_sat(est_angle, fx_mul(dt, rate, 24)));
        // covariance propagation
        dtp11 = fx_mul(dt, cov[3], 24);
        t = sub_sat(sub_sat(dtp11, cov[1]), cov[2]);
        t = add_sat(t, {24'd0, q_angle_noise, 8'd0});
        cov[0] = sat_cov(add_sat(cov[0], fx_mul(dt, t, 24)));
        cov[1] = sat_cov(sub_sat(cov[1], dtp11));
        cov[2] = sat_cov(sub_sat(cov[2], dtp11));
        cov[3] = sat_cov(add_sat(cov[3], fx_mul({32'd0, q_bias_noise}, dt, 16)));
        // gains; zero innovation covariance leaves both at zero
        s = add_sat(cov[0], {24'd0, r_meas_noise, 8'd0});
        k0 = 0;
        k1 = 0;
        if (s != 0) begin
            k0 = fx_gain(cov[0], s);
            k1 = fx_gain(cov[2], s);
        end
        y = 64'(meas_ang) - est_angle;
        est_angle = sat_q16(add_sat(est_angle, fx_mul(k0, y, 32)));
        est_bias  = sat_q16(add_sat(est_bias, fx_mul(k1, y, 32)));
        p00 = cov[0];
        p01 = cov[1];
        cov[0] = sat_cov(sub_sat(cov[0], fx_mul(k0, p00, 32)));
        cov[1] = sat_cov(sub_sat(cov[1], fx_mul(k0, p01, 32)));
        cov[2] = sat_cov(sub_sat(cov[2], fx_mul(k1, p00, 32)));
        cov[3] = sat_cov(sub_sat(cov[3], fx_mul(k1, p01, 32)));
        r.angle = est_angle[31:0];
        r.bias  = est_bias[31:0];
        r.rate  = rate[31:0];
        return r;
    endfunction

    // ---------------- drivers ----------------
    // Offer one request; valid stays high on return
    task automatic send_sample(input logic signed [31:0] ang, input logic signed [31:0] rate,
                               input logic [24:0] dt);
        bit ready;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_measured_angle <= ang;
        i_measured_rate  <= rate;
        i_elapsed_time   <= dt;
        forever begin
            @(negedge i_clk);
            ready = !o_stall;
            @(posedge i_clk);
            if (ready) break;
        end
        expected_q.push_back(kf_update(ang, rate, dt));
        req_cnt++;
    endtask

    // Lower valid and wait for all outstanding results
    task automatic wait_drained();
        i_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ANGLE_NOISE: q_angle_noise = val;
            REG_BIAS_NOISE:  q_bias_noise  = val;
            REG_MEAS_NOISE:  r_meas_noise  = val;
            default: ;
        endcase
        cfg_cnt++;
        @(posedge i_clk);
    endtask

    task automatic cfg_all(input logic [31:0] apn, input logic [31:0] bpn,
                           input logic [31:0] mn);
        cfg_write(REG_ANGLE_NOISE, apn);
        cfg_write(REG_BIAS_NOISE, bpn);
        cfg_write(REG_MEAS_NOISE, mn);
    endtask

    // Mostly plausible IMU samples, some full-range noise
    task automatic send_random();
        logic signed [31:0] ang, rate;
        logic [24:0] dt;
        if ($urandom_range(0, 9) < 8) begin
            ang  = $signed($urandom_range(0, 23592960)) - 32'sd11796480;
            rate = $signed($urandom_range(0, 32768000)) - 32'sd16384000;
            dt   = 25'($urandom_range(0, 1 << 20));
        end else begin
            ang  = $urandom;
            rate = $urandom;
            dt   = 25'($urandom);
        end
        send_sample(ang, rate, dt);
    endtask

    // ---------------- tests ----------------
    // Zero noise everywhere keeps S at zero, so the gains are skipped
    task automatic test_zero_innovation();
        cfg_all(32'd0, 32'd0, 32'd0);
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_sample(32'sh0010_0000, 32'sh0002_0000, 25'h010_0000);
        send_sample(-32'sh0010_0000, -32'sh0002_0000, 25'h100_0000);
        send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 25'h1FF_FFFF);
        wait_drained();
    endtask

    task automatic test_field_extremes();
        cfg_all(APN_RST, BPN_RST, MN_RST);
        send_sample(32'sh7FFF_FFFF, 32'sh0, 25'h0);
        send_sample(32'sh8000_0000, 32'sh0, 25'h100_0000);
        send_sample(32'sh0, 32'sh7FFF_FFFF, 25'h100_0000);
        send_sample(32'sh0, 32'sh8000_0000, 25'h1FF_FFFF);
        send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 25'h1FF_FFFF);
        send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 25'h000_0001);
        send_sample(32'sh0, 32'sh0, 25'h0);
        send_sample(32'sh005A_0000, 32'shFFF6_0000, 25'h004_1893);
        send_sample(-32'sh005A_0000, 32'sh000A_0000, 25'h004_1893);
        send_sample(32'shFFFF_FFFF, 32'sh0000_0001, 25'h0AA_AAAA);
        send_sample(32'sh5555_5555, 32'shAAAA_AAAA, 25'h155_5555);
        wait_drained();
    endtask

    // Noise register extremes, including huge values
    task automatic test_noise_sweep();
        logic [31:0] settings [6][3];
        settings = '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                     '{32'd0, 32'd0, 32'd1},
                     '{32'hFFFF_FFFF, 32'd0, 32'd1},
                     '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                     '{$urandom, $urandom, $urandom},
                     '{APN_RST, BPN_RST, MN_RST}};
        foreach (settings[i]) begin
            cfg_all(settings[i][0], settings[i][1], settings[i][2]);
            repeat (60) send_random();
            wait_drained();
        end
    endtask

    // Receiver holds off for long while requests keep coming
    task automatic test_backpressure();
        hold_cycles = 1500;
        repeat (6) send_random();
        wait_drained();
    endtask

    task automatic test_pause_and_resume();
        repeat (20) send_random();
        wait_drained();
        repeat (20) send_random();
    endtask

    task automatic test_random_stream(input int n);
        repeat (n) send_random();
    endtask

    // ---------------- result checking ----------------
    always @(posedge i_clk) begin
        t_filter_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            rsp_cnt++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result angle=%h bias=%h rate=%h", $time,
                         o_filtered_angle, o_estimated_bias, o_corrected_rate);
                err_cnt++;
            end else begin
                e = expected_q.pop_front();
                if (e.angle !== o_filtered_angle) begin
                    $display("%0t: filtered_angle expected %h actual %h", $time,
                             e.angle, o_filtered_angle);
                    err_cnt++;
                end
                if (e.bias !== o_estimated_bias) begin
                    $display("%0t: estimated_bias expected %h actual %h", $time,
                             e.bias, o_estimated_bias);
                    err_cnt++;
                end
                if (e.rate !== o_corrected_rate) begin
                    $display("%0t: corrected_rate expected %h actual %h", $time,
                             e.rate, o_corrected_rate);
                    err_cnt++;
                end
            end
        end
    end

    // Receiver stall: long hold on request, else random bursts while idle_on is set
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("angle_bias_kalman_filter: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_stall          = 1'b0;
        i_measured_angle = '0;
        i_measured_rate  = '0;
        i_elapsed_time   = '0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        err_cnt = 0; req_cnt = 0; rsp_cnt = 0; cfg_cnt = 0;
        quiet_cycles = 0; hold_cycles = 0; stall_left = 0;
        idle_on = 1'b1;
        q_angle_noise = APN_RST;
        q_bias_noise  = BPN_RST;
        r_meas_noise  = MN_RST;
        est_angle = 0;
        est_bias  = 0;
        foreach (cov[i]) cov[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_innovation();
        test_field_extremes();
        test_noise_sweep();
        cfg_all(APN_RST, BPN_RST, MN_RST);
        test_backpressure();
        test_pause_and_resume();
        test_random_stream(800);
        idle_on = 1'b0;
        test_random_stream(230);

        i_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Covered %0d requests, %0d results, %0d register writes over", req_cnt,
                 rsp_cnt, cfg_cnt);
        $display("zero-gain, saturating, extreme-noise and backpressure scenarios");
        if (err_cnt == 0) begin
            $display("angle_bias_kalman_filter: match");
        end else begin
            $display("angle_bias_kalman_filter: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/abkf_pkg.sv
rtl/abkf_mul.sv
rtl/abkf_div.sv
rtl/angle_bias_kalman_filter.sv
dv/tb_angle_bias_kalman_filter.sv
